>>> rtl/core/load_cell_adc_reader_with_tare_macros.svh
// Assertion macros used by the load cell reader checker.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef LOAD_CELL_ADC_READER_WITH_TARE_MACROS_SVH
`define LOAD_CELL_ADC_READER_WITH_TARE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LCR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LCR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/lcr_pkg.sv
// Shared types and constants of the load cell reader.
// Depends on nothing; imported by every module of the block but the divider.
`default_nettype none

package lcr_pkg;

   localparam int CODE_BITS_DEF  = 24;
   localparam int RAW_BITS       = 24;
   localparam int WEIGHT_BITS    = 14;
   localparam int GAP_BITS       = 24;
   localparam int LIMIT_BITS     = 16;
   localparam int FRAC_BITS      = 8;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = 24;
   localparam int WEIGHT_MAX_MAG = 8191;

   localparam logic [GAP_BITS-1:0]   GAP_RESET   = 24'd25600;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd5000;

   // request command codes
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_TARE   = 2'd1;
   localparam logic [1:0] CMD_WEIGHT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_GAP   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_LIMIT = 2'd1;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT,
      PH_HIGH,
      PH_LOW,
      PH_XHIGH,
      PH_XLOW
   } phase_type;

   typedef enum logic [1:0] {
      ST_READY,
      ST_DIVIDE,
      ST_PUSH
   } ctrl_state_type;

   typedef struct packed {
      logic start_read;
      logic kind_weight;
      logic shift_bit;
      logic finish;
      logic load_res;
      logic clk_level;
      logic take_weight;
      logic push_out;
   } cmd_type;

   typedef struct packed {
      logic last_bit;
      logic read_kind;
      logic div_done;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/core/lcr_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none

module lcr_divider #(
   parameter int DIVIDEND_BITS = 32,
   parameter int DIVISOR_BITS  = 24
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [DIVIDEND_BITS-1:0] dividend,
   input  wire logic [DIVISOR_BITS-1:0]  divisor,
   output logic                          done,
   output logic [DIVIDEND_BITS-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_BITS - 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  dvs_ff, dvs_in;
   logic [DIVIDEND_BITS-1:0] dq_ff, dq_in;
   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    diff;
   logic                     ge;

   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, dq_ff[DIVIDEND_BITS-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dq_in   = dq_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         dq_in   = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         dq_in  = {dq_ff[DIVIDEND_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dq_ff  <= dq_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

`default_nettype wire

>>> rtl/core/lcr_datapath.sv
// Datapath of the load cell reader: shift register, tare, config, divider,
// result and output registers. Depends on lcr_pkg and lcr_divider.
`default_nettype none

module lcr_datapath
   import lcr_pkg::*;
#(
   parameter int CODE_BITS = CODE_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  wire logic                     data_pin,
   input  wire cmd_type                  cmd,
   output sts_type                       sts,
   output logic                          rsp_clock_pin,
   output logic                          rsp_done_res,
   output logic                          rsp_done_kind,
   output logic [RAW_BITS-1:0]           rsp_raw_code,
   output logic signed [WEIGHT_BITS-1:0] rsp_weight
);

   localparam int CNT_W   = $clog2(CODE_BITS);
   localparam int DIV_W   = CODE_BITS + FRAC_BITS;
   localparam int RAW_EXT = (CODE_BITS > RAW_BITS) ? CODE_BITS : RAW_BITS;
   localparam logic [CODE_BITS-1:0] CODE_MSB = {1'b1, {(CODE_BITS-1){1'b0}}};
   localparam logic [CNT_W-1:0]     CNT_LAST = CNT_W'(CODE_BITS - 1);

   logic [GAP_BITS-1:0]   gap_ff, gap_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic [CODE_BITS-1:0]  shift_ff, shift_in;
   logic [CODE_BITS-1:0]  tare_ff, tare_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  kind_ff, kind_in;
   logic                  zero_ff, zero_in;
   logic                  neg_ff, neg_in;

   logic                          res_clock_ff, res_clock_in;
   logic                          res_done_ff, res_done_in;
   logic                          res_kind_ff, res_kind_in;
   logic [RAW_BITS-1:0]           res_raw_ff, res_raw_in;
   logic signed [WEIGHT_BITS-1:0] res_wgt_ff, res_wgt_in;

   logic                          out_clock_ff, out_clock_in;
   logic                          out_done_ff, out_done_in;
   logic                          out_kind_ff, out_kind_in;
   logic [RAW_BITS-1:0]           out_raw_ff, out_raw_in;
   logic signed [WEIGHT_BITS-1:0] out_wgt_ff, out_wgt_in;

   logic [CODE_BITS-1:0]   code;
   logic [RAW_EXT-1:0]     code_ext;
   logic [CODE_BITS-1:0]   mag;
   logic                   code_below;
   logic                   div_start;
   logic                   div_done;
   logic [DIV_W-1:0]       quot;
   logic                   over;
   logic [WEIGHT_BITS-1:0] q_low;
   logic [WEIGHT_BITS-1:0] wgt_val;

   // undo the offset-binary sign bit
   assign code       = shift_ff ^ CODE_MSB;
   assign code_ext   = RAW_EXT'(code);
   assign code_below = code < tare_ff;
   assign mag        = code_below ? (tare_ff - code) : (code - tare_ff);
   assign div_start  = cmd.finish && kind_ff;

   lcr_divider #(
      .DIVIDEND_BITS(DIV_W),
      .DIVISOR_BITS (GAP_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend({mag, {FRAC_BITS{1'b0}}}),
      .divisor (gap_ff),
      .done    (div_done),
      .quotient(quot)
   );

   // drop results above the limit or outside the signed output range
   assign over    = (quot > DIV_W'(limit_ff)) || (quot > DIV_W'(WEIGHT_MAX_MAG));
   assign q_low   = quot[WEIGHT_BITS-1:0];
   assign wgt_val = (zero_ff || over) ? '0 : (neg_ff ? (~q_low + 1'b1) : q_low);

   always_comb begin
      gap_in   = gap_ff;
      limit_in = limit_ff;
      if (csr_write) begin
         case (csr_index)
            REG_GAP:   gap_in   = csr_wdata[GAP_BITS-1:0];
            REG_LIMIT: limit_in = csr_wdata[LIMIT_BITS-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      shift_in = shift_ff;
      tare_in  = tare_ff;
      count_in = count_ff;
      kind_in  = kind_ff;
      zero_in  = zero_ff;
      neg_in   = neg_ff;
      if (cmd.start_read) begin
         shift_in = '0;
         count_in = '0;
         kind_in  = cmd.kind_weight;
      end
      if (cmd.shift_bit) begin
         shift_in = {shift_ff[CODE_BITS-2:0], data_pin};
         count_in = count_ff + 1'b1;
      end
      if (cmd.finish) begin
         count_in = '0;
         zero_in  = (code == tare_ff) || (gap_ff == '0);
         neg_in   = code_below;
         if (!kind_ff) begin
            tare_in = code;
         end
      end
   end

   always_comb begin
      res_clock_in = res_clock_ff;
      res_done_in  = res_done_ff;
      res_kind_in  = res_kind_ff;
      res_raw_in   = res_raw_ff;
      res_wgt_in   = res_wgt_ff;
      if (cmd.load_res) begin
         res_clock_in = cmd.clk_level;
         res_done_in  = cmd.finish;
         res_kind_in  = cmd.finish && kind_ff;
         res_raw_in   = cmd.finish ? code_ext[RAW_BITS-1:0] : '0;
         res_wgt_in   = '0;
      end
      if (cmd.take_weight) begin
         res_wgt_in = $signed(wgt_val);
      end
   end

   always_comb begin
      out_clock_in = out_clock_ff;
      out_done_in  = out_done_ff;
      out_kind_in  = out_kind_ff;
      out_raw_in   = out_raw_ff;
      out_wgt_in   = out_wgt_ff;
      if (cmd.push_out) begin
         out_clock_in = res_clock_ff;
         out_done_in  = res_done_ff;
         out_kind_in  = res_kind_ff;
         out_raw_in   = res_raw_ff;
         out_wgt_in   = res_wgt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff   <= GAP_RESET;
         limit_ff <= LIMIT_RESET;
         shift_ff <= '0;
         tare_ff  <= '0;
         count_ff <= '0;
         kind_ff  <= 1'b0;
      end else begin
         gap_ff   <= gap_in;
         limit_ff <= limit_in;
         shift_ff <= shift_in;
         tare_ff  <= tare_in;
         count_ff <= count_in;
         kind_ff  <= kind_in;
      end
      zero_ff      <= zero_in;
      neg_ff       <= neg_in;
      res_clock_ff <= res_clock_in;
      res_done_ff  <= res_done_in;
      res_kind_ff  <= res_kind_in;
      res_raw_ff   <= res_raw_in;
      res_wgt_ff   <= res_wgt_in;
      out_clock_ff <= out_clock_in;
      out_done_ff  <= out_done_in;
      out_kind_ff  <= out_kind_in;
      out_raw_ff   <= out_raw_in;
      out_wgt_ff   <= out_wgt_in;
   end

   assign sts.last_bit  = count_ff == CNT_LAST;
   assign sts.read_kind = kind_ff;
   assign sts.div_done  = div_done;

   assign rsp_clock_pin = out_clock_ff;
   assign rsp_done_res  = out_done_ff;
   assign rsp_done_kind = out_kind_ff;
   assign rsp_raw_code  = out_raw_ff;
   assign rsp_weight    = out_wgt_ff;

endmodule

`default_nettype wire

>>> rtl/core/lcr_ctrl.sv
// Controller of the load cell reader: serial phase sequencer, word handling
// and output valid. Depends on lcr_pkg.
`default_nettype none

module lcr_ctrl
   import lcr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_command,
   input  wire logic       req_data_pin,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire sts_type    sts,
   output cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic           out_valid_ff, out_valid_in;

   assign req_stall = state_ff != ST_READY;
   assign rsp_valid = out_valid_ff;

   // commands
   always_comb begin
      cmd = '0;
      if (state_ff == ST_READY && req_valid) begin
         cmd.load_res = 1'b1;
         case (phase_ff)
            PH_IDLE: begin
               cmd.start_read  = req_command inside {CMD_TARE, CMD_WEIGHT};
               cmd.kind_weight = req_command == CMD_WEIGHT;
            end
            PH_HIGH, PH_XHIGH: cmd.clk_level = 1'b1;
            PH_LOW:            cmd.shift_bit = 1'b1;
            PH_XLOW:           cmd.finish    = 1'b1;
            default:           ;
         endcase
      end
      cmd.take_weight = (state_ff == ST_DIVIDE) && sts.div_done;
      cmd.push_out    = (state_ff == ST_PUSH) && (!out_valid_ff || !rsp_stall);
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      out_valid_in = cmd.push_out || (out_valid_ff && rsp_stall);
      case (state_ff)
         ST_READY: begin
            if (req_valid) begin
               state_in = (phase_ff == PH_XLOW && sts.read_kind) ? ST_DIVIDE : ST_PUSH;
            end
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (cmd.push_out) begin
               state_in = ST_READY;
            end
         end
         default: state_in = ST_READY;
      endcase
      if (state_ff == ST_READY && req_valid) begin
         case (phase_ff)
            PH_IDLE:  phase_in = cmd.start_read ? PH_WAIT : PH_IDLE;
            PH_WAIT:  phase_in = req_data_pin ? PH_WAIT : PH_HIGH;
            PH_HIGH:  phase_in = PH_LOW;
            PH_LOW:   phase_in = sts.last_bit ? PH_XHIGH : PH_HIGH;
            PH_XHIGH: phase_in = PH_XLOW;
            PH_XLOW:  phase_in = PH_IDLE;
            default:  phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READY;
         phase_ff     <= PH_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/load_cell_adc_reader_with_tare.sv
// A taken tick word is loaded into the result register and moves on to the output register
// from the push state; the tick that ends a weight read first waits on the divider.
// The next tick word is taken only once the previous word has moved to the output register.
// A single output register holds the finished word, so the next tick is taken while it waits.
// Reset (synchronous, active high): serial phase idle, tare and shift register zero,
// gap 25600, limit 5000, output register empty. No clearing pass.
`default_nettype none

module load_cell_adc_reader_with_tare
   import lcr_pkg::*;
#(
   parameter int CODE_BITS = CODE_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // tick words in
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_command,
   input  wire logic                     req_data_pin,
   // result words out
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_clock_pin,
   output logic                          rsp_done_res,
   output logic                          rsp_done_kind,
   output logic [RAW_BITS-1:0]           rsp_raw_code,
   output logic signed [WEIGHT_BITS-1:0] rsp_weight,
   // register writes
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // Registers are plain flops: always take the write.
   assign csr_ready = 1'b1;

   // The controller walks the serial phases, one per accepted tick word:
   // idle, wait for data low, then high/low pulse pairs shifting in each bit,
   // then the extra pulse whose low half completes the read. A completed
   // weight read holds the input side while the divider runs.
   lcr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_data_pin(req_data_pin),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   // The datapath holds the code being shifted in, the tare, the register
   // file and the divider; it builds each result word and then hands it to
   // the output register when the controller advances it.
   lcr_datapath #(
      .CODE_BITS(CODE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .data_pin     (req_data_pin),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_clock_pin(rsp_clock_pin),
      .rsp_done_res (rsp_done_res),
      .rsp_done_kind(rsp_done_kind),
      .rsp_raw_code (rsp_raw_code),
      .rsp_weight   (rsp_weight)
   );

endmodule

`default_nettype wire

>>> rtl/core/lcr_checker.sv
// Port-level checks of the load cell reader, bound to the top level.
// Depends on lcr_pkg and the assertion macro header.
`default_nettype none
`include "load_cell_adc_reader_with_tare_macros.svh"

module lcr_checker
   import lcr_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic                     rsp_clock_pin,
   input wire logic                     rsp_done_res,
   input wire logic                     rsp_done_kind,
   input wire logic [RAW_BITS-1:0]      rsp_raw_code,
   input wire logic [WEIGHT_BITS-1:0]   rsp_weight
);

   `LCR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_raw_code) && $stable(rsp_weight), "stalled result word changed")
   `LCR_ASSERT_IMP(a_idle_zero, clock, reset, rsp_valid && !rsp_done_res, rsp_raw_code == '0 && rsp_weight == '0 && !rsp_done_kind, "non-completing word carries data")
   `LCR_ASSERT_IMP(a_done_low, clock, reset, rsp_valid && rsp_done_res, !rsp_clock_pin, "read completed on a clock high tick")
   `LCR_ASSERT_IMP(a_tare_zero, clock, reset, rsp_valid && rsp_done_res && !rsp_done_kind, rsp_weight == '0, "tare word carries a weight")

endmodule

bind load_cell_adc_reader_with_tare lcr_checker u_lcr_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_clock_pin(rsp_clock_pin),
   .rsp_done_res (rsp_done_res),
   .rsp_done_kind(rsp_done_kind),
   .rsp_raw_code (rsp_raw_code),
   .rsp_weight   (rsp_weight)
);

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the load cell reader with tare: serial tick words in, one
// result word per tick out, plus register writes. Depends on lcr_pkg and the top level RTL.
// A built-in predictor of the serial read and the weight arithmetic gives the expected words.
module testbench;
   import lcr_pkg::*;

   localparam int CODE_W = CODE_BITS_DEF;
   localparam logic [CODE_W-1:0] SIGN_FLIP = {1'b1, {(CODE_W-1){1'b0}}};
   // command 3 has no meaning and must act as a plain tick
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // indexes past the register list, writes there must change nothing
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_B = 2'd3;
   // time left after the last drain for the slowest tick (end of a weight read)
   localparam int TAIL_CYCLES = CODE_W + 20;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_TICKS = 50;
   localparam longint TIMEOUT_UNITS = 4_000_000;

   typedef struct packed {
      logic                          clock_pin;
      logic                          done_res;
      logic                          done_kind;
      logic [RAW_BITS-1:0]           raw_code;
      logic signed [WEIGHT_BITS-1:0] weight;
   } tick_word_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [1:0]                    req_command;
   logic                          req_data_pin;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic                          rsp_clock_pin;
   logic                          rsp_done_res;
   logic                          rsp_done_kind;
   logic [RAW_BITS-1:0]           rsp_raw_code;
   logic signed [WEIGHT_BITS-1:0] rsp_weight;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_IDX_BITS-1:0]       csr_index;
   logic [CSR_DATA_BITS-1:0]      csr_wdata;

   load_cell_adc_reader_with_tare uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_data_pin  (req_data_pin),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_clock_pin (rsp_clock_pin),
      .rsp_done_res  (rsp_done_res),
      .rsp_done_kind (rsp_done_kind),
      .rsp_raw_code  (rsp_raw_code),
      .rsp_weight    (rsp_weight),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // Predicted copy of the serial reader state and its registers.
   phase_type         pred_phase;
   int                pred_bits;
   logic [CODE_W-1:0] pred_shift;
   logic [CODE_W-1:0] pred_tare;
   logic              pred_kind;
   logic [GAP_BITS-1:0]   pred_gap;
   logic [LIMIT_BITS-1:0] pred_limit;

   // Result words still owed by the block, oldest first.
   tick_word_type expected_words[$];

   int error_count;
   int ticks_sent;
   bit tx_idle_on;
   bit rx_idle_on;
   int hold_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Generous fixed limit; a hung block or a lost word ends here.
   initial begin
      #(TIMEOUT_UNITS);
      $display("testbench: errors");
      $finish;
   end

   // Grams from a finished weight read: signed difference to the tare, scaled by the Q16.8
   // gap, truncated toward zero. Zero for a code equal to the tare, a zero gap, anything
   // above the limit or anything that does not fit the 14-bit result.
   function automatic logic signed [WEIGHT_BITS-1:0] grams_from_code(logic [CODE_W-1:0] code);
      longint                 diff;
      longint unsigned        mag;
      longint unsigned        quot;
      logic [WEIGHT_BITS-1:0] mag_w;
      if (code == pred_tare || pred_gap == '0)
         return '0;
      diff = longint'(code) - longint'(pred_tare);
      mag = (diff < 0) ? longint'(-diff) : diff;
      quot = (mag << FRAC_BITS) / longint'(pred_gap);
      if (quot > longint'(pred_limit) || quot > WEIGHT_MAX_MAG)
         return '0;
      mag_w = quot[WEIGHT_BITS-1:0];
      return (diff < 0) ? -mag_w : mag_w;
   endfunction

   // Advance the predicted reader by one tick and give the word that tick produces.
   function automatic tick_word_type next_tick_word(logic [1:0] cmd, logic dat);
      tick_word_type     word;
      logic [CODE_W-1:0] code;
      word = '0;
      case (pred_phase)
         PH_IDLE: begin
            if (cmd == CMD_TARE || cmd == CMD_WEIGHT) begin
               pred_kind = (cmd == CMD_WEIGHT);
               pred_shift = '0;
               pred_bits = 0;
               pred_phase = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (!dat)
               pred_phase = PH_HIGH;
         end
         PH_HIGH: begin
            word.clock_pin = 1'b1;
            pred_phase = PH_LOW;
         end
         PH_LOW: begin
            pred_shift = {pred_shift[CODE_W-2:0], dat};
            pred_bits++;
            pred_phase = (pred_bits >= CODE_W) ? PH_XHIGH : PH_HIGH;
         end
         PH_XHIGH: begin
            word.clock_pin = 1'b1;
            pred_phase = PH_XLOW;
         end
         PH_XLOW: begin
            code = pred_shift ^ SIGN_FLIP;
            word.done_res = 1'b1;
            word.done_kind = pred_kind;
            word.raw_code = code;
            if (!pred_kind)
               pred_tare = code;
            else
               word.weight = grams_from_code(code);
            pred_phase = PH_IDLE;
            pred_bits = 0;
         end
         default: begin
            pred_phase = PH_IDLE;
         end
      endcase
      return word;
   endfunction

   // Code that lands near a given weight under the current tare and gap.
   function automatic logic [CODE_W-1:0] code_for_grams(longint grams, longint jitter);
      longint delta;
      delta = (grams * longint'(pred_gap)) / 256 + jitter;
      return CODE_W'(longint'(pred_tare) + delta);
   endfunction

   // Command carried by ticks of a running read; noisy reads throw in commands the block
   // must ignore while busy.
   function automatic logic [1:0] busy_cmd(bit noisy);
      return noisy ? 2'($urandom_range(0, 3)) : CMD_TICK;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= 100)
         $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
   endtask

   // Send one tick word. Start and end at a falling edge; hold the word until taken.
   task automatic send_tick(input logic [1:0] cmd, input logic dat);
      int gap;
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_data_pin <= dat;
      do begin
         @(posedge clock);
      end while (req_stall);
      expected_words.push_back(next_tick_word(cmd, dat));
      ticks_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold off until every owed word has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   // Finish any read left open by stray commands: zeros pass the wait and fill the bits.
   task automatic close_open_read();
      while (pred_phase != PH_IDLE)
         send_tick(CMD_TICK, 1'b0);
   endtask

   // One whole serial read returning the given offset-binary code.
   task automatic do_read(input logic [1:0] cmd, input logic [CODE_W-1:0] code, input bit noisy);
      logic [CODE_W-1:0] bits_out;
      int                waits;
      bits_out = code ^ SIGN_FLIP;
      close_open_read();
      send_tick(cmd, 1'($urandom_range(0, 1)));
      // converter not ready yet: data held high
      waits = noisy ? $urandom_range(0, 4) : 0;
      repeat (waits) send_tick(busy_cmd(noisy), 1'b1);
      send_tick(busy_cmd(noisy), 1'b0);
      for (int i = CODE_W - 1; i >= 0; i--) begin
         send_tick(busy_cmd(noisy), 1'($urandom_range(0, 1)));
         send_tick(busy_cmd(noisy), bits_out[i]);
      end
      // extra pulse, high then low; the low tick reports
      send_tick(busy_cmd(noisy), 1'($urandom_range(0, 1)));
      send_tick(busy_cmd(noisy), 1'($urandom_range(0, 1)));
   endtask

   // Register write, only with the reader idle and nothing owed.
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      close_open_read();
      wait_for_drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      if (idx == REG_GAP)
         pred_gap = data[GAP_BITS-1:0];
      else if (idx == REG_LIMIT)
         pred_limit = data[LIMIT_BITS-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_limit(input logic [LIMIT_BITS-1:0] lim);
      // upper data bits are junk the register must drop
      write_reg(REG_LIMIT, {8'($urandom), lim});
   endtask

   // Plain ticks and the unused command at idle, both data levels.
   task automatic test_idle_ticks();
      send_tick(CMD_TICK, 1'b0);
      send_tick(CMD_TICK, 1'b1);
      send_tick(CMD_UNUSED, 1'b0);
      send_tick(CMD_UNUSED, 1'b1);
   endtask

   // Tare at both code extremes, a weight far from the tare, a weight equal to the tare.
   task automatic test_tare_extremes();
      do_read(CMD_TARE, '1, 1'b0);
      do_read(CMD_WEIGHT, '0, 1'b0);
      do_read(CMD_TARE, '0, 1'b0);
      do_read(CMD_WEIGHT, pred_tare, 1'b1);
   endtask

   // Both signs of weight and both sides of the limit at the reset settings.
   task automatic test_weight_sign_and_limit();
      do_read(CMD_TARE, SIGN_FLIP, 1'b0);
      do_read(CMD_WEIGHT, code_for_grams(1234, 0), 1'b0);
      do_read(CMD_WEIGHT, code_for_grams(-1234, 0), 1'b1);
      do_read(CMD_WEIGHT, code_for_grams(5000, 0), 1'b0);
      do_read(CMD_WEIGHT, code_for_grams(5001, 0), 1'b0);
      do_read(CMD_WEIGHT, code_for_grams(-5000, 0), 1'b0);
   endtask

   // Register extremes: unit gap with the widest limit hits the 14-bit edge, then zero gap,
   // full gap, zero limit, and writes past the register list.
   task automatic test_register_extremes();
      write_reg(REG_GAP, 24'd1);
      write_limit(16'hFFFF);
      do_read(CMD_WEIGHT, pred_tare + 24'd31, 1'b0);
      do_read(CMD_WEIGHT, pred_tare + 24'd32, 1'b0);
      do_read(CMD_WEIGHT, pred_tare - 24'd31, 1'b0);
      do_read(CMD_WEIGHT, pred_tare - 24'd32, 1'b0);
      write_reg(REG_GAP, 24'd0);
      do_read(CMD_WEIGHT, pred_tare + 24'd1000, 1'b0);
      write_reg(REG_GAP, 24'hFFFFFF);
      do_read(CMD_WEIGHT, pred_tare + 24'h7FFFFF, 1'b0);
      write_limit(16'd0);
      do_read(CMD_WEIGHT, pred_tare + 24'h7FFFFF, 1'b0);
      write_reg(REG_SPARE_A, 24'($urandom));
      write_reg(REG_SPARE_B, 24'($urandom));
      write_reg(REG_GAP, GAP_RESET);
      write_limit(LIMIT_RESET);
      do_read(CMD_WEIGHT, code_for_grams(-777, 0), 1'b0);
   endtask

   // Random reads under several settings; mostly well-formed reads with random content,
   // the rest stray ticks that may open reads on their own.
   task automatic test_random_settings();
      int     start;
      int     pick;
      int     span;
      longint grams;
      bit     noisy;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               write_reg(REG_GAP, GAP_RESET);
               write_limit(LIMIT_RESET);
            end
            1: begin
               write_reg(REG_GAP, 24'($urandom_range(64, 65535)));
               write_limit(16'($urandom_range(100, 9000)));
            end
            2: begin
               write_reg(REG_GAP, 24'd1);
               write_limit(16'hFFFF);
            end
            3: begin
               write_reg(REG_GAP, 24'hFFFFFF);
               write_limit(16'($urandom));
            end
            4: begin
               write_reg(REG_GAP, 24'($urandom_range(1, 2000)));
               write_limit(16'd8191);
            end
            default: begin
               write_reg(REG_GAP, 24'($urandom_range(1, 24'hFFFFFF)));
               write_limit(16'($urandom_range(0, 50)));
            end
         endcase
         start = ticks_sent;
         while (ticks_sent - start < PHASE_TICKS) begin
            pick = $urandom_range(0, 9);
            noisy = ($urandom_range(0, 3) != 0);
            span = (pred_limit > 9000) ? 9000 : pred_limit;
            if (pick == 0) begin
               do_read(CMD_TARE, 24'($urandom), noisy);
            end else if (pick == 1) begin
               do_read(CMD_WEIGHT, 24'($urandom), noisy);
            end else if (pick == 2) begin
               // stray ticks at idle, any command
               repeat ($urandom_range(1, 8))
                  send_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
               close_open_read();
            end else begin
               grams = $urandom_range(0, span + span / 8 + 2);
               if ($urandom_range(0, 1))
                  grams = -grams;
               do_read(CMD_WEIGHT, code_for_grams(grams, $urandom_range(0, 3)), noisy);
            end
         end
      end
   endtask

   // Receiver holds off for a long stretch while ticks keep coming, so the block fills up
   // and stalls its input.
   task automatic test_backpressure();
      write_reg(REG_GAP, GAP_RESET);
      write_limit(LIMIT_RESET);
      tx_idle_on = 1'b0;
      hold_cycles = HOLD_OFF_CYCLES;
      do_read(CMD_TARE, 24'($urandom), 1'b0);
      do_read(CMD_WEIGHT, code_for_grams(-42, 1), 1'b1);
      tx_idle_on = 1'b1;
      wait_for_drain();
   endtask

   // Last stretch at full rate, no idling on either side.
   task automatic test_quiet_finish();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      repeat (4)
         do_read(CMD_WEIGHT, code_for_grams($urandom_range(0, 4000), 0), 1'b1);
      do_read(CMD_TARE, 24'($urandom), 1'b1);
      do_read(CMD_WEIGHT, code_for_grams(-2500, 0), 1'b0);
   endtask

   // Receiver: random stall bursts, or a long hold-off counted down here.
   initial begin : drive_rsp_stall
      int burst;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 6) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted result word with the oldest owed one.
   always @(posedge clock) begin : check_words
      tick_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, raw_code", rsp_raw_code, 0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_clock_pin !== want.clock_pin)
               report_mismatch("clock_pin", rsp_clock_pin, want.clock_pin);
            if (rsp_done_res !== want.done_res)
               report_mismatch("done_res", rsp_done_res, want.done_res);
            if (rsp_done_kind !== want.done_kind)
               report_mismatch("done_kind", rsp_done_kind, want.done_kind);
            if (rsp_raw_code !== want.raw_code)
               report_mismatch("raw_code", rsp_raw_code, want.raw_code);
            if (rsp_weight !== want.weight)
               report_mismatch("weight", rsp_weight, $signed(want.weight));
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_TICK;
      req_data_pin = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_GAP;
      csr_wdata = '0;
      pred_phase = PH_IDLE;
      pred_bits = 0;
      pred_shift = '0;
      pred_tare = '0;
      pred_kind = 1'b0;
      pred_gap = GAP_RESET;
      pred_limit = LIMIT_RESET;
      error_count = 0;
      ticks_sent = 0;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      hold_cycles = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_idle_ticks();
      test_tare_extremes();
      test_weight_sign_and_limit();
      test_register_extremes();
      test_random_settings();
      test_backpressure();
      test_quiet_finish();

      // drain, then let the slowest tick clear before judging
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lcr_pkg.sv
rtl/core/lcr_divider.sv
rtl/core/lcr_datapath.sv
rtl/core/lcr_ctrl.sv
rtl/core/load_cell_adc_reader_with_tare.sv
rtl/core/lcr_checker.sv
verif/testbench.sv
